// ===== rtl/multi_timer_scheduler_macros.svh =====
// Assertion macros for the multi timer scheduler checker.
// Used by multi_timer_scheduler_chk.sv; no other dependencies.
`ifndef MULTI_TIMER_SCHEDULER_MACROS_SVH
`define MULTI_TIMER_SCHEDULER_MACROS_SVH

// clocked, held off during reset
`define MTS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("multi_timer_scheduler assertion failed");

// clocked, checked during reset as well
`define MTS_ASSERT_ALL(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("multi_timer_scheduler assertion failed");

`endif

// ===== rtl/mts_pkg.sv =====
// Shared types and codes for the multi timer scheduler.
// Used by mts_ctrl, mts_dp and the top level; no dependencies.
package mts_pkg;

  localparam int TIMERS_DEF = 16;
  localparam int FRAC_DEF   = 16;
  localparam int MAX_FIRES  = 16;
  localparam int TW         = 48;

  localparam logic [2:0] OP_FRAME   = 3'd0;
  localparam logic [2:0] OP_CREATE  = 3'd1;
  localparam logic [2:0] OP_KILL    = 3'd2;
  localparam logic [2:0] OP_RESCHED = 3'd3;
  localparam logic [2:0] OP_LEVEL   = 3'd4;

  localparam logic [2:0] KIND_FIRED    = 3'd0;
  localparam logic [2:0] KIND_CREATED  = 3'd1;
  localparam logic [2:0] KIND_DONE     = 3'd2;
  localparam logic [2:0] KIND_NOTFOUND = 3'd3;
  localparam logic [2:0] KIND_FULL     = 3'd4;

  localparam logic [1:0] CFG_TICK    = 2'd0;
  localparam logic [1:0] CFG_PERIOD  = 2'd1;
  localparam logic [1:0] CFG_CATCHUP = 2'd2;

  typedef enum logic [1:0] {
    MODE_FIRE,
    MODE_FIND,
    MODE_FREE,
    MODE_LEVEL
  } scan_mode_t;

  typedef enum logic [1:0] {
    ID_ZERO,
    ID_PEND,
    ID_CTR
  } id_sel_t;

  typedef struct packed {
    logic       latch;
    logic       adv;
    logic       chk;
    logic       scan_start;
    scan_mode_t mode;
    logic       fire_apply;
    logic       create_apply;
    logic       kill_apply;
    logic       resched_apply;
    logic       lvl_end;
    logic       nt_upd;
    logic       load_out;
    logic [2:0] out_kind;
    logic       out_last;
    id_sel_t    out_sel;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic best_hit;
    logic think;
  } status_t;

endpackage

// ===== rtl/mts_dp.sv =====
// Datapath of the multi timer scheduler: slot memories, valid bits, time
// registers, configuration registers, slot scanner and result register.
// Depends on mts_pkg.
module mts_dp #(
  parameter int TIMERS        = mts_pkg::TIMERS_DEF,
  parameter int FRACTION_BITS = mts_pkg::FRAC_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mts_pkg::cmd_t             cmd,
  output mts_pkg::status_t          st,
  input  logic                      in_simulating,
  input  logic [mts_pkg::TW-1:0]    in_cur_time,
  input  logic [31:0]               in_delay,
  input  logic                      in_periodic,
  input  logic                      in_map_bound,
  input  logic [31:0]               in_timer_id,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_idx,
  input  logic [31:0]               cfg_data,
  output logic [2:0]                out_kind,
  output logic [31:0]               out_result_id,
  output logic                      out_last
);

  localparam int IW = $clog2(TIMERS);
  localparam int CW = IW + 1;
  localparam logic [15:0] TICK_RST =
    16'((64'd1 << (FRACTION_BITS - 6)) & 64'hFFFF);
  localparam logic [31:0] PER_RST =
    32'(((64'd1 << FRACTION_BITS) + 64'd5) / 64'd10);
  localparam int TWD = mts_pkg::TW;

  logic [TWD-1:0] ut_r, nt_r, lft_r;
  logic           seen_r;
  logic [31:0]    ctr_r;
  logic [15:0]    tick_r;
  logic [31:0]    per_r, lim_r;
  logic           think_r, catch_r;

  logic           sim_l_r, per_l_r, map_l_r;
  logic [TWD-1:0] cur_l_r;
  logic [31:0]    dly_l_r, tid_l_r;

  logic [TIMERS-1:0] valid_r, done_r;
  logic [TWD-1:0] mem_due [TIMERS];
  logic [31:0]    mem_id  [TIMERS];
  logic [31:0]    mem_dly [TIMERS];
  logic           mem_per [TIMERS];
  logic           mem_map [TIMERS];

  logic              scan_r;
  mts_pkg::scan_mode_t mode_r;
  logic [CW-1:0]     cnt_r;
  logic              rd_vld_r;
  logic [IW-1:0]     rd_idx_r;
  logic [TWD-1:0]    rd_due_r;
  logic [31:0]       rd_id_r, rd_dly_r;
  logic              rd_per_r, rd_map_r;

  logic              best_hit_r;
  logic [IW-1:0]     best_idx_r;
  logic [TWD-1:0]    best_due_r;
  logic [31:0]       best_id_r, best_dly_r;
  logic              best_per_r;
  logic [31:0]       pend_id_r;

  logic [2:0]        okind_r;
  logic [31:0]       oid_r;
  logic              olast_r;

  logic              scan_end;
  logic              rd_v;
  logic              cand;
  logic              due_we, dly_we, new_we;
  logic [TWD-1:0]    due_wd;
  logic [31:0]       dly_wd;

  assign scan_end = scan_r && (cnt_r == CW'(TIMERS)) && !rd_vld_r;
  assign rd_v     = valid_r[rd_idx_r];

  always_comb begin
    cand = 1'b0;
    case (mode_r)
      mts_pkg::MODE_FIRE: begin
        cand = rd_v && !done_r[rd_idx_r] && (rd_due_r <= ut_r) &&
               (!best_hit_r || (rd_due_r < best_due_r) ||
                ((rd_due_r == best_due_r) && (rd_id_r < best_id_r)));
      end
      mts_pkg::MODE_FIND:  cand = rd_v && (rd_id_r == tid_l_r) && !best_hit_r;
      mts_pkg::MODE_FREE:  cand = !rd_v && !best_hit_r;
      default:             cand = 1'b0;
    endcase
  end

  always_comb begin
    due_we = 1'b0;
    dly_we = 1'b0;
    new_we = 1'b0;
    due_wd = ut_r + TWD'(dly_l_r);
    dly_wd = dly_l_r;
    if (cmd.fire_apply && best_per_r) begin
      due_we = 1'b1;
      due_wd = ut_r + TWD'(best_dly_r);
    end
    if (cmd.create_apply) begin
      due_we = 1'b1;
      dly_we = 1'b1;
      new_we = 1'b1;
    end
    if (cmd.resched_apply) begin
      due_we = 1'b1;
      dly_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (due_we) mem_due[best_idx_r] <= due_wd;
    if (dly_we) mem_dly[best_idx_r] <= dly_wd;
    if (new_we) begin
      mem_id[best_idx_r]  <= ctr_r + 32'd1;
      mem_per[best_idx_r] <= per_l_r;
      mem_map[best_idx_r] <= map_l_r;
    end
    rd_due_r <= mem_due[cnt_r[IW-1:0]];
    rd_id_r  <= mem_id[cnt_r[IW-1:0]];
    rd_dly_r <= mem_dly[cnt_r[IW-1:0]];
    rd_per_r <= mem_per[cnt_r[IW-1:0]];
    rd_map_r <= mem_map[cnt_r[IW-1:0]];
    rd_idx_r <= cnt_r[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      sim_l_r <= in_simulating;
      cur_l_r <= in_cur_time;
      dly_l_r <= (in_delay == 32'd0) ? 32'd1 : in_delay;
      per_l_r <= in_periodic;
      map_l_r <= in_map_bound;
      tid_l_r <= in_timer_id;
    end
    if (cmd.adv) lft_r <= cur_l_r;
    if (cmd.chk) begin
      think_r <= ut_r >= nt_r;
      catch_r <= (ut_r - nt_r) <= TWD'({1'b0, per_r} + {1'b0, lim_r});
    end
    if (rd_vld_r && cand) begin
      best_idx_r <= rd_idx_r;
      best_due_r <= rd_due_r;
      best_id_r  <= rd_id_r;
      best_dly_r <= rd_dly_r;
      best_per_r <= rd_per_r;
    end
    if (cmd.fire_apply) pend_id_r <= best_id_r;
    if (cmd.load_out) begin
      okind_r <= cmd.out_kind;
      olast_r <= cmd.out_last;
      case (cmd.out_sel)
        mts_pkg::ID_PEND: oid_r <= pend_id_r;
        mts_pkg::ID_CTR:  oid_r <= ctr_r;
        default:          oid_r <= 32'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ut_r       <= '0;
      nt_r       <= '0;
      seen_r     <= 1'b0;
      ctr_r      <= '0;
      tick_r     <= TICK_RST;
      per_r      <= PER_RST;
      lim_r      <= PER_RST;
      valid_r    <= '0;
      done_r     <= '0;
      scan_r     <= 1'b0;
      mode_r     <= mts_pkg::MODE_FIRE;
      cnt_r      <= '0;
      rd_vld_r   <= 1'b0;
      best_hit_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          mts_pkg::CFG_TICK:    tick_r <= cfg_data[15:0];
          mts_pkg::CFG_PERIOD:  per_r  <= cfg_data;
          mts_pkg::CFG_CATCHUP: lim_r  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.adv) begin
        if (sim_l_r && seen_r) ut_r <= ut_r + cur_l_r - lft_r;
        else                   ut_r <= ut_r + TWD'(tick_r);
        seen_r <= 1'b1;
        done_r <= '0;
      end
      if (cmd.lvl_end) seen_r <= 1'b0;
      if (cmd.nt_upd) begin
        if (catch_r) nt_r <= nt_r + TWD'(per_r);
        else         nt_r <= ut_r + TWD'(per_r);
      end
      if (cmd.scan_start) begin
        scan_r     <= 1'b1;
        mode_r     <= cmd.mode;
        cnt_r      <= '0;
        rd_vld_r   <= 1'b0;
        best_hit_r <= 1'b0;
      end else if (scan_r) begin
        if (cnt_r != CW'(TIMERS)) begin
          cnt_r    <= cnt_r + CW'(1);
          rd_vld_r <= 1'b1;
        end else begin
          rd_vld_r <= 1'b0;
        end
        if (scan_end) scan_r <= 1'b0;
        if (rd_vld_r && cand) best_hit_r <= 1'b1;
        if (rd_vld_r && (mode_r == mts_pkg::MODE_LEVEL) && rd_v && rd_map_r)
          valid_r[rd_idx_r] <= 1'b0;
      end
      if (cmd.fire_apply) begin
        done_r[best_idx_r] <= 1'b1;
        if (!best_per_r) valid_r[best_idx_r] <= 1'b0;
      end
      if (cmd.create_apply) begin
        valid_r[best_idx_r] <= 1'b1;
        ctr_r <= ctr_r + 32'd1;
      end
      if (cmd.kill_apply) valid_r[best_idx_r] <= 1'b0;
    end
  end

  assign st.scan_done = scan_end;
  assign st.best_hit  = best_hit_r;
  assign st.think     = think_r;

  assign out_kind      = okind_r;
  assign out_result_id = oid_r;
  assign out_last      = olast_r;

endmodule

// ===== rtl/mts_ctrl.sv =====
// Controller of the multi timer scheduler: request sequencing, fire loop
// and result handshake. Depends on mts_pkg.
module mts_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_op,
  output logic                out_valid,
  input  logic                out_ready,
  output mts_pkg::cmd_t       cmd,
  input  mts_pkg::status_t    st
);

  localparam int FCW = $clog2(mts_pkg::MAX_FIRES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADV,
    S_CHK,
    S_TEST,
    S_SCAN,
    S_DECIDE,
    S_EMIT
  } state_t;

  state_t           state_r, state_nxt;
  logic [2:0]       op_r, op_nxt;
  logic [FCW-1:0]   fcnt_r, fcnt_nxt;
  logic             pend_r, pend_nxt;
  logic [2:0]       em_kind_r, em_kind_nxt;
  logic             em_last_r, em_last_nxt;
  mts_pkg::id_sel_t em_sel_r, em_sel_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    op_nxt        = op_r;
    fcnt_nxt      = fcnt_r;
    pend_nxt      = pend_r;
    em_kind_nxt   = em_kind_r;
    em_last_nxt   = em_last_r;
    em_sel_nxt    = em_sel_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          op_nxt    = in_op;
          case (in_op)
            mts_pkg::OP_FRAME: state_nxt = S_ADV;
            mts_pkg::OP_CREATE: begin
              cmd.scan_start = 1'b1;
              cmd.mode       = mts_pkg::MODE_FREE;
              state_nxt      = S_SCAN;
            end
            mts_pkg::OP_KILL, mts_pkg::OP_RESCHED: begin
              cmd.scan_start = 1'b1;
              cmd.mode       = mts_pkg::MODE_FIND;
              state_nxt      = S_SCAN;
            end
            mts_pkg::OP_LEVEL: begin
              cmd.scan_start = 1'b1;
              cmd.mode       = mts_pkg::MODE_LEVEL;
              state_nxt      = S_SCAN;
            end
            default: begin
              em_kind_nxt = mts_pkg::KIND_DONE;
              em_sel_nxt  = mts_pkg::ID_ZERO;
              em_last_nxt = 1'b1;
              state_nxt   = S_EMIT;
            end
          endcase
        end
      end
      S_ADV: begin
        cmd.adv   = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.chk   = 1'b1;
        state_nxt = S_TEST;
      end
      S_TEST: begin
        if (st.think) begin
          fcnt_nxt       = '0;
          pend_nxt       = 1'b0;
          cmd.scan_start = 1'b1;
          cmd.mode       = mts_pkg::MODE_FIRE;
          state_nxt      = S_SCAN;
        end else begin
          em_kind_nxt = mts_pkg::KIND_DONE;
          em_sel_nxt  = mts_pkg::ID_ZERO;
          em_last_nxt = 1'b1;
          state_nxt   = S_EMIT;
        end
      end
      S_SCAN: begin
        if (st.scan_done) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        em_last_nxt = 1'b1;
        em_sel_nxt  = mts_pkg::ID_ZERO;
        em_kind_nxt = mts_pkg::KIND_DONE;
        case (op_r)
          mts_pkg::OP_FRAME: begin
            if (st.best_hit) begin
              if (!pend_r || out_free) begin
                if (pend_r) begin
                  cmd.load_out  = 1'b1;
                  cmd.out_kind  = mts_pkg::KIND_FIRED;
                  cmd.out_sel   = mts_pkg::ID_PEND;
                  cmd.out_last  = 1'b0;
                  out_valid_nxt = 1'b1;
                end
                cmd.fire_apply = 1'b1;
                pend_nxt       = 1'b1;
                fcnt_nxt       = fcnt_r + FCW'(1);
                if (fcnt_r == FCW'(mts_pkg::MAX_FIRES - 1)) begin
                  cmd.nt_upd  = 1'b1;
                  em_kind_nxt = mts_pkg::KIND_FIRED;
                  em_sel_nxt  = mts_pkg::ID_PEND;
                  state_nxt   = S_EMIT;
                end else begin
                  cmd.scan_start = 1'b1;
                  cmd.mode       = mts_pkg::MODE_FIRE;
                  state_nxt      = S_SCAN;
                end
              end
            end else begin
              cmd.nt_upd = 1'b1;
              if (pend_r) begin
                em_kind_nxt = mts_pkg::KIND_FIRED;
                em_sel_nxt  = mts_pkg::ID_PEND;
              end
              state_nxt = S_EMIT;
            end
          end
          mts_pkg::OP_CREATE: begin
            if (st.best_hit) begin
              cmd.create_apply = 1'b1;
              em_kind_nxt      = mts_pkg::KIND_CREATED;
              em_sel_nxt       = mts_pkg::ID_CTR;
            end else begin
              em_kind_nxt = mts_pkg::KIND_FULL;
            end
            state_nxt = S_EMIT;
          end
          mts_pkg::OP_KILL: begin
            if (st.best_hit) cmd.kill_apply = 1'b1;
            else             em_kind_nxt = mts_pkg::KIND_NOTFOUND;
            state_nxt = S_EMIT;
          end
          mts_pkg::OP_RESCHED: begin
            if (st.best_hit) cmd.resched_apply = 1'b1;
            else             em_kind_nxt = mts_pkg::KIND_NOTFOUND;
            state_nxt = S_EMIT;
          end
          mts_pkg::OP_LEVEL: begin
            cmd.lvl_end = 1'b1;
            state_nxt   = S_EMIT;
          end
          default: state_nxt = S_EMIT;
        endcase
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          cmd.out_kind  = em_kind_r;
          cmd.out_sel   = em_sel_r;
          cmd.out_last  = em_last_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= mts_pkg::OP_FRAME;
      fcnt_r      <= '0;
      pend_r      <= 1'b0;
      em_kind_r   <= mts_pkg::KIND_DONE;
      em_last_r   <= 1'b0;
      em_sel_r    <= mts_pkg::ID_ZERO;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      fcnt_r      <= fcnt_nxt;
      pend_r      <= pend_nxt;
      em_kind_r   <= em_kind_nxt;
      em_last_r   <= em_last_nxt;
      em_sel_r    <= em_sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/multi_timer_scheduler.sv =====
// Timer table of TIMERS one-shot or periodic timers, advanced by frame
// requests; one request is handled at a time. Create, kill, reschedule and
// level end requests scan the slot table once, one slot per cycle. A frame
// that reaches its check time rescans the table once per fired timer (at
// most 16 per frame) plus one closing scan when fewer than 16 fire, after
// its time update. Results leave through an output register, so the next
// request can enter while the last result waits.
// Depends on mts_pkg, mts_ctrl and mts_dp.
module multi_timer_scheduler #(
  parameter int TIMERS        = mts_pkg::TIMERS_DEF,
  parameter int FRACTION_BITS = mts_pkg::FRAC_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic        in_simulating,
  input  logic [47:0] in_cur_time,
  input  logic [31:0] in_delay,
  input  logic        in_periodic,
  input  logic        in_map_bound,
  input  logic [31:0] in_timer_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [31:0] out_result_id,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_data
);

  mts_pkg::cmd_t    cmd;
  mts_pkg::status_t st;

  mts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .st        (st)
  );

  mts_dp #(
    .TIMERS        (TIMERS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .in_simulating (in_simulating),
    .in_cur_time   (in_cur_time),
    .in_delay      (in_delay),
    .in_periodic   (in_periodic),
    .in_map_bound  (in_map_bound),
    .in_timer_id   (in_timer_id),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_data      (cfg_data),
    .out_kind      (out_kind),
    .out_result_id (out_result_id),
    .out_last      (out_last)
  );

endmodule

// ===== rtl/multi_timer_scheduler_chk.sv =====
// Port-level checker for the multi timer scheduler, bound to the top level.
// Depends on multi_timer_scheduler_macros.svh and mts_pkg.
`include "multi_timer_scheduler_macros.svh"

module mts_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [31:0] out_result_id,
  input logic        out_last
);

  `MTS_ASSERT_ALL(a_rst_no_out, clk, !rst_n |=> !out_valid)
  `MTS_ASSERT(a_one_req, clk, rst_n, (in_valid && in_ready) |=> !in_ready)
  `MTS_ASSERT(a_zero_id, clk, rst_n, (out_valid && (out_kind == mts_pkg::KIND_DONE || out_kind == mts_pkg::KIND_NOTFOUND || out_kind == mts_pkg::KIND_FULL)) |-> (out_result_id == 32'd0))
  `MTS_ASSERT(a_single_last, clk, rst_n, (out_valid && (out_kind != mts_pkg::KIND_FIRED)) |-> out_last)
  `MTS_ASSERT(a_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_result_id) && $stable(out_last)))

endmodule

bind multi_timer_scheduler mts_chk u_mts_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_kind      (out_kind),
  .out_result_id (out_result_id),
  .out_last      (out_last)
);

// ===== tb/tb_top.sv =====
// Self-checking bench for multi_timer_scheduler: random and directed requests,
// results checked in order against a timer table model. Needs mts_pkg and the RTL.
module tb_top;

  localparam int SLOTS = 16;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 400;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] id;
    logic        last;
  } timer_result_t;

  class timer_table_model;
    bit          live[SLOTS];
    bit          rearm[SLOTS];
    bit          level_bound[SLOTS];
    bit [31:0]   tid[SLOTS];
    bit [47:0]   due[SLOTS];
    bit [31:0]   dly[SLOTS];
    bit [47:0]   utime, think_at, prev_frame;
    bit          seen;
    bit [31:0]   id_ctr;
    bit [15:0]   tick;
    bit [31:0]   period, catchup;
    timer_result_t pending_results[$];
    int          fails;

    function new();
      for (int i = 0; i < SLOTS; i++) live[i] = 0;
      utime = 0; think_at = 0; prev_frame = 0; seen = 0; id_ctr = 0;
      tick = 16'd1024; period = 32'd6554; catchup = 32'd6554; fails = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      if (idx == mts_pkg::CFG_TICK) tick = val[15:0];
      else if (idx == mts_pkg::CFG_PERIOD) period = val;
      else if (idx == mts_pkg::CFG_CATCHUP) catchup = val;
    endfunction

    function void push(logic [2:0] k, logic [31:0] id);
      timer_result_t r;
      r.kind = k; r.id = id; r.last = 0;
      pending_results.push_back(r);
    endfunction

    function int find_slot(bit [31:0] id);
      for (int i = 0; i < SLOTS; i++) if (live[i] && tid[i] == id) return i;
      return -1;
    endfunction

    function void note_request(logic [2:0] op, logic sim, logic [47:0] cur,
                               logic [31:0] delay, logic per, logic mb,
                               logic [31:0] id);
      int n, s, best;
      bit fired[SLOTS];
      bit [47:0] lag;
      bit [31:0] d;
      n = 0;
      d = (delay == 0) ? 32'd1 : delay;
      if (op == mts_pkg::OP_FRAME) begin
        if (sim && seen) utime = utime + cur - prev_frame;
        else utime = utime + tick;
        prev_frame = cur;
        seen = 1;
        if (utime >= think_at) begin
          lag = utime - think_at;
          for (int i = 0; i < SLOTS; i++) fired[i] = 0;
          while (n < 16) begin
            best = -1;
            for (int i = 0; i < SLOTS; i++) begin
              if (!live[i] || fired[i] || due[i] > utime) continue;
              if (best < 0 || due[i] < due[best] ||
                  (due[i] == due[best] && tid[i] < tid[best])) best = i;
            end
            if (best < 0) break;
            fired[best] = 1;
            push(mts_pkg::KIND_FIRED, tid[best]);
            n++;
            if (rearm[best]) due[best] = utime + dly[best];
            else live[best] = 0;
          end
          if ({16'd0, lag} <= {32'd0, period} + {32'd0, catchup})
            think_at = think_at + period;
          else
            think_at = utime + period;
        end
        if (n == 0) push(mts_pkg::KIND_DONE, 0);
      end else if (op == mts_pkg::OP_CREATE) begin
        s = -1;
        for (int i = 0; i < SLOTS; i++) if (!live[i]) begin s = i; break; end
        if (s < 0) push(mts_pkg::KIND_FULL, 0);
        else begin
          id_ctr++;
          live[s] = 1; rearm[s] = per; level_bound[s] = mb; tid[s] = id_ctr;
          dly[s] = d; due[s] = utime + d;
          push(mts_pkg::KIND_CREATED, id_ctr);
        end
      end else if (op == mts_pkg::OP_KILL || op == mts_pkg::OP_RESCHED) begin
        s = find_slot(id);
        if (s < 0) push(mts_pkg::KIND_NOTFOUND, 0);
        else begin
          if (op == mts_pkg::OP_KILL) live[s] = 0;
          else begin dly[s] = d; due[s] = utime + d; end
          push(mts_pkg::KIND_DONE, 0);
        end
      end else if (op == mts_pkg::OP_LEVEL) begin
        for (int i = 0; i < SLOTS; i++) if (level_bound[i]) live[i] = 0;
        seen = 0;
        push(mts_pkg::KIND_DONE, 0);
      end else begin
        push(mts_pkg::KIND_DONE, 0);
      end
      pending_results[$].last = 1;
    endfunction

    function void check_result(logic [2:0] k, logic [31:0] id, logic lst);
      timer_result_t e;
      if (pending_results.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result kind=%0d id=%0d last=%0d", k, id, lst);
        return;
      end
      e = pending_results.pop_front();
      if (k !== e.kind || id !== e.id || lst !== e.last) begin
        fails++;
        if (fails <= 10)
          $display("mismatch: exp kind=%0d id=%0d last=%0d, got kind=%0d id=%0d last=%0d",
                   e.kind, e.id, e.last, k, id, lst);
      end
    endfunction

    function bit [31:0] some_live_id();
      int picks[$];
      for (int i = 0; i < SLOTS; i++) if (live[i]) picks.push_back(i);
      if (picks.size() == 0) return id_ctr;
      return tid[picks[$urandom_range(picks.size() - 1)]];
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_valid, in_ready;
  logic [2:0]  in_op;
  logic        in_simulating;
  logic [47:0] in_cur_time;
  logic [31:0] in_delay;
  logic        in_periodic, in_map_bound;
  logic [31:0] in_timer_id;
  logic        out_valid, out_ready;
  logic [2:0]  out_kind;
  logic [31:0] out_result_id;
  logic        out_last;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_data;

  timer_table_model model;
  logic        hold_req;
  bit          hold_done;
  int          hold_cnt, rx_mode, rx_phase, quiet_cycles, burst_left;
  logic [47:0] game_time;

  multi_timer_scheduler uut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 0;
      quiet_cycles <= 0;
    end else begin
      if (out_valid && out_ready) model.check_result(out_kind, out_result_id, out_last);
      if (in_valid && in_ready)
        model.note_request(in_op, in_simulating, in_cur_time, in_delay, in_periodic,
                           in_map_bound, in_timer_id);
      if ((out_valid && out_ready) || (in_valid && in_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("multi_timer_scheduler regression: fail");
        $finish;
      end
      rx_phase <= rx_phase + 1;
      if (rx_phase % 64 == 0) rx_mode <= $urandom_range(2);
      if (hold_req && !hold_done && hold_cnt == 0) begin
        hold_cnt <= 400;
        hold_done <= 1;
        out_ready <= 0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_ready <= (hold_cnt == 1);
      end else if (rx_mode == 0) out_ready <= 1;
      else if (rx_mode == 1) out_ready <= ($urandom_range(9) < 7);
      else out_ready <= (rx_phase % 3 == 0);
    end
  end

  task automatic send_req(logic [2:0] op, logic sim, logic [47:0] cur, logic [31:0] delay,
                          logic per, logic mb, logic [31:0] id);
    in_valid <= 1; in_op <= op; in_simulating <= sim; in_cur_time <= cur;
    in_delay <= delay; in_periodic <= per; in_map_bound <= mb; in_timer_id <= id;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    else begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1; cfg_idx <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    model.set_reg(idx, val);
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    @(posedge clk);
    while (model.pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_req(bit allow_hold, int k);
    int pick;
    logic [31:0] dl, id;
    pick = $urandom_range(99);
    dl = ($urandom_range(19) == 0) ? $urandom : $urandom_range(0, 40000);
    if (allow_hold && k == 20) hold_req <= 1;
    if (pick < 45) begin
      case ($urandom_range(9))
        0: game_time = {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
        1: game_time = game_time - $urandom_range(50000);
        default: game_time = game_time + $urandom_range(30000);
      endcase
      send_req(mts_pkg::OP_FRAME, $urandom_range(3) != 0, game_time, $urandom, $urandom,
               $urandom, $urandom);
    end else if (pick < 70) begin
      send_req(mts_pkg::OP_CREATE, $urandom, {$urandom, $urandom}, dl, $urandom, $urandom,
               $urandom);
    end else if (pick < 92) begin
      id = ($urandom_range(4) == 0) ? $urandom : model.some_live_id();
      send_req(($urandom_range(1) == 0) ? mts_pkg::OP_KILL : mts_pkg::OP_RESCHED, $urandom,
               {$urandom, $urandom}, dl, $urandom, $urandom, id);
    end else if (pick < 97) begin
      send_req(mts_pkg::OP_LEVEL, $urandom, {$urandom, $urandom}, $urandom, $urandom,
               $urandom, $urandom);
    end else begin
      send_req(3'($urandom_range(5, 7)), $urandom, {$urandom, $urandom}, $urandom,
               $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    logic [31:0] ticks[6], periods[6], catchups[6];
    model = new();
    rst_n = 0; in_valid = 0; in_op = 0; in_simulating = 0; in_cur_time = 0;
    in_delay = 0; in_periodic = 0; in_map_bound = 0; in_timer_id = 0;
    out_ready = 0; cfg_we = 0; cfg_idx = 0; cfg_data = 0;
    hold_req = 0; hold_done = 0; hold_cnt = 0; rx_mode = 0; rx_phase = 0;
    quiet_cycles = 0; burst_left = 0; game_time = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, full table, every op
    send_req(mts_pkg::OP_FRAME, 0, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0);
    send_req(mts_pkg::OP_FRAME, 1, 48'h0, 0, 0, 0, 0);
    send_req(mts_pkg::OP_CREATE, 0, 0, 32'd0, 1, 1, 0);
    send_req(mts_pkg::OP_CREATE, 0, 0, 32'hFFFF_FFFF, 0, 0, 0);
    for (int i = 0; i < 15; i++)
      send_req(mts_pkg::OP_CREATE, 0, 0, 32'd100 + i, i % 2, i % 3 == 0, 0);
    send_req(mts_pkg::OP_KILL, 0, 0, 0, 0, 0, 32'd0);
    send_req(mts_pkg::OP_RESCHED, 0, 0, 32'd0, 0, 0, 32'd2);
    send_req(mts_pkg::OP_KILL, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
    send_req(mts_pkg::OP_FRAME, 1, 48'd200000, 0, 0, 0, 0);
    send_req(mts_pkg::OP_FRAME, 0, 48'd0, 0, 0, 0, 0);
    send_req(mts_pkg::OP_LEVEL, 0, 0, 0, 0, 0, 0);
    send_req(3'd7, 1, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF);
    wait_idle();

    ticks = '{32'd1, 32'd65535, 32'd1024, 32'd300, 32'd40000, 32'd7};
    periods = '{32'd1, 32'd6554, 32'd20000, 32'hFFFF_FFFF, 32'd500, 32'd3000};
    catchups = '{32'd0, 32'hFFFF_FFFF, 32'd6554, 32'd0, 32'd100000, 32'd10};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(mts_pkg::CFG_TICK, ticks[ph]);
      write_reg(mts_pkg::CFG_PERIOD, periods[ph]);
      write_reg(mts_pkg::CFG_CATCHUP, catchups[ph]);
      for (int k = 0; k < 75; k++) random_req(ph == 1, k);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (model.fails == 0 && model.pending_results.size() == 0)
      $display("multi_timer_scheduler regression: pass");
    else
      $display("multi_timer_scheduler regression: fail");
    $finish;
  end
endmodule
